// ===== rtl/imu_ca_pkg.sv =====
// shared types, constants and tables of the imu attitude estimator
package imu_ca_pkg;

  // cordic iteration count default
  localparam int CORDIC_STEPS_DEF = 16;
  // atan table depth
  localparam int ATAN_DEPTH = 24;
  // step count of the interval scaling division
  localparam int DIV_STEPS = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_ALPHA    = 3'd0;
  localparam logic [2:0] CFG_GAIN     = 3'd1;
  localparam logic [2:0] CFG_OFFSET_X = 3'd2;
  localparam logic [2:0] CFG_OFFSET_Y = 3'd3;
  localparam logic [2:0] CFG_OFFSET_Z = 3'd4;

  // register reset values and the alpha clamp limit
  localparam logic [16:0] ALPHA_RST = 17'd64225;
  localparam logic [15:0] GAIN_RST  = 16'd2235;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // inverse cordic gain, q0.16
  localparam logic [15:0] INV_GAIN = 16'd39797;
  // 1e6 us times 256 splits into 2^14 times 15625; half of it rounds to nearest
  localparam logic [54:0] DT_HALF  = 55'd128000000;
  localparam logic [13:0] DT_ODD   = 14'd15625;
  // ceil(2^44 / 15625), exact quotient for dividends below 2^30
  localparam logic [30:0] DT_RECIP = 31'd1125899907;

  // datapath commands
  typedef struct packed {
    logic       load_in;
    logic       c1_init;
    logic       c2_init;
    logic       c_step;
    logic       scale;
    logic       angle;
    logic       gm1;
    logic       gm2;
    logic       div_init;
    logic       div_step;
    logic       dlt_store;
    logic       mix_mul;
    logic       mix_add;
    logic       out_load;
    logic       tilt_sel;
    logic [1:0] axis;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic out_busy;
  } sts_t;

  // atan(2^-i) in q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/imu_ca_ctrl.sv =====
// sequencing controller of the imu attitude estimator
module imu_ca_ctrl #(
  parameter int CORDIC_STEPS = imu_ca_pkg::CORDIC_STEPS_DEF,
  parameter int CNT_W = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imu_ca_pkg::sts_t   sts_i,
  output imu_ca_pkg::cmd_t   cmd_o,
  output logic [CNT_W-1:0]   step_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_C1I, ST_C1, ST_SCL, ST_C2I, ST_C2, ST_ANG, ST_GM1, ST_GM2,
    ST_DVI, ST_DV, ST_DST, ST_MXM, ST_MXA, ST_FIN
  } state_e;

  localparam logic [CNT_W-1:0] CordLast = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] DivLast  = CNT_W'(imu_ca_pkg::DIV_STEPS - 1);

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             tilt_q;
  logic [1:0]       axis_q;

  // state, counter and index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tilt_q  <= 1'b0;
      axis_q  <= 2'd0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            tilt_q  <= 1'b0;
            state_q <= ST_C1I;
          end
        end
        ST_C1I: begin
          cnt_q   <= '0;
          state_q <= ST_C1;
        end
        ST_C1: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CordLast) state_q <= ST_SCL;
        end
        ST_SCL: state_q <= ST_C2I;
        ST_C2I: begin
          cnt_q   <= '0;
          state_q <= ST_C2;
        end
        ST_C2: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CordLast) state_q <= ST_ANG;
        end
        ST_ANG: begin
          if (!tilt_q) begin
            tilt_q  <= 1'b1;
            state_q <= ST_C1I;
          end else begin
            axis_q  <= 2'd0;
            state_q <= ST_GM1;
          end
        end
        ST_GM1: state_q <= ST_GM2;
        ST_GM2: state_q <= ST_DVI;
        ST_DVI: begin
          cnt_q   <= '0;
          state_q <= ST_DV;
        end
        ST_DV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) state_q <= ST_DST;
        end
        ST_DST: begin
          if (axis_q == 2'd2) begin
            axis_q  <= 2'd0;
            state_q <= ST_MXM;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_GM1;
          end
        end
        ST_MXM: state_q <= ST_MXA;
        ST_MXA: begin
          if (axis_q == 2'd2) begin
            state_q <= ST_FIN;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_MXM;
          end
        end
        ST_FIN: begin
          if (!sts_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.tilt_sel  = tilt_q;
    cmd_o.axis      = axis_q;
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.c1_init   = (state_q == ST_C1I);
    cmd_o.c_step    = (state_q == ST_C1) || (state_q == ST_C2);
    cmd_o.scale     = (state_q == ST_SCL);
    cmd_o.c2_init   = (state_q == ST_C2I);
    cmd_o.angle     = (state_q == ST_ANG);
    cmd_o.gm1       = (state_q == ST_GM1);
    cmd_o.gm2       = (state_q == ST_GM2);
    cmd_o.div_init  = (state_q == ST_DVI);
    cmd_o.div_step  = (state_q == ST_DV);
    cmd_o.dlt_store = (state_q == ST_DST);
    cmd_o.mix_mul   = (state_q == ST_MXM);
    cmd_o.mix_add   = (state_q == ST_MXA);
    cmd_o.out_load  = (state_q == ST_FIN) && !sts_i.out_busy;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign step_o     = cnt_q;

endmodule

// ===== rtl/imu_ca_dp.sv =====
// datapath of the imu attitude estimator: cordic, gyro scaling, blend, output register
module imu_ca_dp #(
  parameter int CNT_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [16:0]       cfg_data_i,
  input  logic [119:0]      in_data_i,
  input  imu_ca_pkg::cmd_t  cmd_i,
  input  logic [CNT_W-1:0]  step_i,
  output imu_ca_pkg::sts_t  sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [95:0]       out_data_o
);

  localparam int CW = 35;
  localparam int ZW = 34;

  // configuration
  logic        [16:0] alpha_q;
  logic        [15:0] gain_q;
  logic signed [15:0] off_q [3];

  // latched item
  logic signed [15:0] acc_in_q [3];
  logic signed [15:0] rate_q [3];
  logic        [19:0] us_q;

  // cordic
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic        [31:0]   m_q;
  logic                 zero_q;
  logic signed [31:0]   tilt_q [2];

  // gyro scaling and division
  logic signed [34:0] p1_q;
  logic signed [55:0] p2_q;
  logic        [29:0] dd_q;
  logic        [15:0] dlo_q;
  logic        [60:0] dp_q;
  logic        [24:0] quo_q;
  logic               neg_q;
  logic signed [27:0] dlt_q [3];

  // blend and state
  logic signed [50:0] pg_q, pa_q;
  logic signed [31:0] store_q [3];
  logic               valid_q;
  logic               out_valid_q;
  logic        [95:0] out_q;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return (e < 0) ? 17'(-e) : 17'(e);
  endfunction

  // operand selection for the tilt in progress
  logic signed [15:0] ta, tb;
  logic signed [16:0] tnum;
  logic        [16:0] ta_abs, tb_abs;
  always_comb begin
    ta     = cmd_i.tilt_sel ? acc_in_q[1] : acc_in_q[0];
    tb     = acc_in_q[2];
    tnum   = cmd_i.tilt_sel ? -17'(acc_in_q[0]) : 17'(acc_in_q[1]);
    ta_abs = abs16(ta);
    tb_abs = abs16(tb);
  end

  // cordic step terms
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  logic        [47:0]   mprod;
  logic signed [ZW-1:0] zr;
  always_comb begin
    dx    = cy_q >>> step_i;
    dy    = cx_q >>> step_i;
    at    = $signed({2'b00, imu_ca_pkg::atan_q30(5'(step_i))});
    mprod = cx_q[31:0] * imu_ca_pkg::INV_GAIN + 48'd32768;
    zr    = cz_q + ZW'(8192);
  end

  // blend terms
  logic        [16:0] al;
  logic signed [17:0] al_s, bl_s;
  logic signed [32:0] gsum;
  logic signed [31:0] acc_sel;
  logic signed [51:0] bsum;
  logic signed [55:0] p2_abs;
  always_comb begin
    al      = (alpha_q > imu_ca_pkg::ALPHA_ONE) ? imu_ca_pkg::ALPHA_ONE : alpha_q;
    al_s    = $signed({1'b0, al});
    bl_s    = $signed(18'd65536 - {1'b0, al});
    gsum    = 33'(store_q[cmd_i.axis]) + 33'(dlt_q[cmd_i.axis]);
    acc_sel = cmd_i.axis[0] ? tilt_q[1] : tilt_q[0];
    bsum    = 52'(pg_q) + 52'(pa_q) + 52'sd32768;
    p2_abs  = p2_q[55] ? -p2_q : p2_q;
  end

  // rounded dividend and remainder of the first base-2^16 division digit
  logic [54:0] dsum;
  logic [29:0] dv_qd, dv_rem;
  always_comb begin
    dsum   = p2_abs[54:0] + imu_ca_pkg::DT_HALF;
    dv_qd  = {21'd0, dp_q[52:44]} * {16'd0, imu_ca_pkg::DT_ODD};
    dv_rem = dd_q - dv_qd;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= imu_ca_pkg::ALPHA_RST;
      gain_q  <= imu_ca_pkg::GAIN_RST;
      off_q   <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        imu_ca_pkg::CFG_ALPHA:    alpha_q  <= cfg_data_i;
        imu_ca_pkg::CFG_GAIN:     gain_q   <= cfg_data_i[15:0];
        imu_ca_pkg::CFG_OFFSET_X: off_q[0] <= cfg_data_i[15:0];
        imu_ca_pkg::CFG_OFFSET_Y: off_q[1] <= cfg_data_i[15:0];
        imu_ca_pkg::CFG_OFFSET_Z: off_q[2] <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // item latch, cordic, gyro, division and blend product datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int k = 0; k < 3; k++) begin
        acc_in_q[k] <= in_data_i[16*k +: 16];
        rate_q[k]   <= in_data_i[48 + 16*k +: 16];
      end
      us_q <= in_data_i[115:96];
    end
    if (cmd_i.c1_init) begin
      cx_q <= $signed({4'd0, ta_abs, 14'd0});
      cy_q <= $signed({4'd0, tb_abs, 14'd0});
      cz_q <= '0;
    end
    if (cmd_i.c2_init) begin
      cx_q   <= $signed({3'd0, m_q});
      cy_q   <= $signed({{4{tnum[16]}}, tnum, 14'd0});
      cz_q   <= '0;
      zero_q <= (m_q == 32'd0) && (tnum == 17'sd0);
    end
    if (cmd_i.c_step) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + at;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - at;
      end
    end
    if (cmd_i.scale) m_q <= mprod[47:16];
    if (cmd_i.angle) begin
      tilt_q[cmd_i.tilt_sel] <= zero_q ? 32'sd0 : 32'($signed(zr[ZW-1:14]));
    end
    if (cmd_i.gm1) begin
      p1_q <= (18'(rate_q[cmd_i.axis]) - 18'(off_q[cmd_i.axis]))
              * $signed({1'b0, gain_q});
    end
    if (cmd_i.gm2) p2_q <= p1_q * $signed({1'b0, us_q});
    // divide by 2^14 with a shift, then by 15625 in two base-2^16 digits
    if (cmd_i.div_init) begin
      neg_q <= p2_q[55];
      dd_q  <= {8'd0, dsum[51:30]};
      dlo_q <= dsum[29:14];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (!step_i[0]) begin
        dp_q <= dd_q * imu_ca_pkg::DT_RECIP;
      end else if (!step_i[1]) begin
        quo_q[24:16] <= dp_q[52:44];
        dd_q         <= {dv_rem[13:0], dlo_q};
      end else begin
        quo_q[15:0] <= dp_q[59:44];
      end
    end
    if (cmd_i.dlt_store) begin
      dlt_q[cmd_i.axis] <= neg_q ? -$signed({3'd0, quo_q}) : $signed({3'd0, quo_q});
    end
    if (cmd_i.mix_mul) begin
      pg_q <= gsum * al_s;
      pa_q <= acc_sel * bl_s;
    end
  end

  // angle stores, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      store_q     <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mix_add) begin
        if (cmd_i.axis == 2'd2) begin
          store_q[2] <= valid_q ? sat32(36'(gsum)) : 32'sd0;
        end else begin
          store_q[cmd_i.axis] <= valid_q ? sat32(bsum[51:16]) : acc_sel;
        end
      end
      if (cmd_i.out_load) begin
        valid_q     <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= {store_q[2], store_q[1], store_q[0]};
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== rtl/imu_complementary_attitude.sv =====
// top level of the imu complementary-filter attitude estimator
// One sample set at a time: roll and pitch tilts each take two passes of the shared
// cordic unit with init, scale and angle steps, each of the three gyro axes takes a
// multiply and reciprocal-multiply divide, then the blend and the output load follow;
// the next item is accepted once the block is back in idle. The result sits in an
// output register, so the next item is taken even if the previous result is not yet
// collected; a new result waits in the final state until it is. Angles are q16.16
// radians; the first item after reset loads the accelerometer angles into roll and
// pitch and clears yaw.
module imu_complementary_attitude #(
  parameter int CORDIC_STEPS = imu_ca_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, interval_us, zero pad
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle
  output logic [95:0]  m_axis_tdata
);

  localparam int CntMax = (CORDIC_STEPS > imu_ca_pkg::DIV_STEPS) ?
                          CORDIC_STEPS : imu_ca_pkg::DIV_STEPS;
  localparam int CNT_W = $clog2(CntMax);

  imu_ca_pkg::cmd_t cmd;
  imu_ca_pkg::sts_t sts;
  logic [CNT_W-1:0] step;

  // controller
  imu_ca_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .step_o     (step)
  );

  // datapath
  imu_ca_dp #(
    .CNT_W(CNT_W)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .step_i      (step),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/imu_ca_chk.sv =====
// port-level checks of the imu attitude estimator, bound to the top level
module imu_ca_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an accepted item closes the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after accept");

  // a fresh result appears only while an item was in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // an item accepted while no result is pending does not produce its result at once
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 !m_axis_tvalid)
    else $error("result too early");

endmodule

bind imu_complementary_attitude imu_ca_chk u_chk (.*);
